FILE: rtl/sign_magnitude_accumulator_alu_core_assert.svh
// Assertion macros for the sign-magnitude accumulator ALU core.
// Included by the top level; no other dependencies.
`ifndef SIGN_MAGNITUDE_ACCUMULATOR_ALU_CORE_ASSERT_SVH
`define SIGN_MAGNITUDE_ACCUMULATOR_ALU_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMACC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/smacc_pkg.sv
// Shared types and constants of the sign-magnitude accumulator ALU.
// No dependencies.
package smacc_pkg;

   localparam int MAG_BITS  = 23;
   localparam int WORD_BITS = MAG_BITS + 1;
   localparam int CNT_BITS  = 5;
   localparam int OP_BITS   = 4;
   localparam int ITER_W    = $clog2(MAG_BITS);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAG_BITS - 1);

   localparam int REQ_DATA_BITS = ((WORD_BITS + CNT_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * WORD_BITS + 5;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic [MAG_BITS-1:0]  mag_type;
   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_HOLD = 4'd0,
      OP_LDA  = 4'd1,
      OP_LDB  = 4'd2,
      OP_ADD  = 4'd3,
      OP_SUB  = 4'd4,
      OP_MPY  = 4'd5,
      OP_DIV  = 4'd6,
      OP_AND  = 4'd7,
      OP_OR   = 4'd8,
      OP_XOR  = 4'd9,
      OP_SHR  = 4'd10,
      OP_SHL  = 4'd11,
      OP_ATOB = 4'd12,
      OP_SWAP = 4'd13,
      OP_SKGT = 4'd14,
      OP_SKNE = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADDNEG,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_WB
   } state_type;

   // Shared adder request and answer
   typedef struct packed {
      word_type x;
      word_type y;
      logic     sub;
   } alu_req_type;

   typedef struct packed {
      word_type res;
      logic     cout;   // carry out; on subtract, set when x >= y
   } alu_rsp_type;

   // Finished transaction from the engine to the output register
   typedef struct packed {
      logic     push;
      word_type acc_a;
      word_type acc_b;
      logic     ovf;
      logic     skip;
   } result_type;

endpackage

FILE: rtl/smacc_alu.sv
// Shared add/subtract unit of the accumulator engine.
// Depends on smacc_pkg.
module smacc_alu (
   input  smacc_pkg::alu_req_type req,
   output smacc_pkg::alu_rsp_type rsp
);

   logic [smacc_pkg::WORD_BITS-1:0] y_eff;
   logic [smacc_pkg::WORD_BITS:0]   sum;

   assign y_eff = req.sub ? ~req.y : req.y;
   assign sum   = {1'b0, req.x} + {1'b0, y_eff} + {{smacc_pkg::WORD_BITS{1'b0}}, req.sub};

   assign rsp.res  = sum[smacc_pkg::WORD_BITS-1:0];
   assign rsp.cout = sum[smacc_pkg::WORD_BITS];

endmodule

FILE: rtl/smacc_engine.sv
// Sequencer and A/B/overflow registers of the accumulator ALU; multiply
// and divide iterate one magnitude bit per cycle on smacc_alu.
// Depends on smacc_pkg and smacc_alu.
module smacc_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  smacc_pkg::op_type                 req_op,
   input  smacc_pkg::word_type               req_word,
   input  logic [smacc_pkg::CNT_BITS-1:0]    req_cnt,
   input  logic                              slot_free,
   output smacc_pkg::result_type             result
);

   localparam int MB = smacc_pkg::MAG_BITS;

   smacc_pkg::state_type state_ff, state_in;
   smacc_pkg::op_type    op_ff, op_in;
   smacc_pkg::word_type  opw_ff, opw_in;
   logic [smacc_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   smacc_pkg::word_type  a_ff, a_in;
   smacc_pkg::word_type  b_ff, b_in;
   logic                 ovf_ff, ovf_in;
   logic                 skip_ff, skip_in;
   logic [smacc_pkg::ITER_W-1:0] iter_ff, iter_in;

   smacc_pkg::alu_req_type alu_req;
   smacc_pkg::alu_rsp_type alu_rsp;

   smacc_pkg::mag_type a_mag, b_mag, w_mag;
   logic a_sgn, b_sgn, w_sgn, eff_sgn, a_neg, w_neg, prod_sgn, push;
   smacc_pkg::word_type shifted;

   assign a_mag   = a_ff[MB-1:0];
   assign b_mag   = b_ff[MB-1:0];
   assign w_mag   = opw_ff[MB-1:0];
   assign a_sgn   = a_ff[MB];
   assign b_sgn   = b_ff[MB];
   assign w_sgn   = opw_ff[MB];
   // Subtract is add with the operand sign flipped
   assign eff_sgn = w_sgn ^ (op_ff == smacc_pkg::OP_SUB);
   assign a_neg   = a_sgn && (a_mag != '0);
   assign w_neg   = w_sgn && (w_mag != '0);
   assign prod_sgn = (b_sgn ^ w_sgn) && ({a_mag, b_mag} != '0);
   assign shifted = {a_mag, b_mag[MB-1]};

   smacc_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smacc_pkg::ST_IDLE;
         a_ff     <= '0;
         b_ff     <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      opw_ff  <= opw_in;
      cnt_ff  <= cnt_in;
      skip_ff <= skip_in;
      iter_ff <= iter_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smacc_pkg::ST_IDLE: begin
            if (req_valid) state_in = smacc_pkg::ST_EXEC;
         end
         smacc_pkg::ST_EXEC: begin
            case (op_ff) inside
               smacc_pkg::OP_ADD, smacc_pkg::OP_SUB: begin
                  if ((a_sgn != eff_sgn) && !alu_rsp.cout) state_in = smacc_pkg::ST_ADDNEG;
                  else state_in = smacc_pkg::ST_WB;
               end
               smacc_pkg::OP_MPY: state_in = smacc_pkg::ST_MUL;
               smacc_pkg::OP_DIV: begin
                  // improper divide goes straight to write-back
                  state_in = alu_rsp.cout ? smacc_pkg::ST_WB : smacc_pkg::ST_DIV;
               end
               default: state_in = smacc_pkg::ST_WB;
            endcase
         end
         smacc_pkg::ST_ADDNEG: state_in = smacc_pkg::ST_WB;
         smacc_pkg::ST_MUL, smacc_pkg::ST_DIV: begin
            if (iter_ff == smacc_pkg::ITER_LAST) state_in = smacc_pkg::ST_SIGN;
         end
         smacc_pkg::ST_SIGN: state_in = smacc_pkg::ST_WB;
         smacc_pkg::ST_WB: begin
            if (slot_free) state_in = smacc_pkg::ST_IDLE;
         end
         default: state_in = smacc_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_ready   = 1'b0;
      push        = 1'b0;
      alu_req.x   = '0;
      alu_req.y   = '0;
      alu_req.sub = 1'b0;
      op_in   = op_ff;
      opw_in  = opw_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      ovf_in  = ovf_ff;
      skip_in = skip_ff;
      iter_in = iter_ff;
      unique case (state_ff)
         smacc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = req_op;
               opw_in = req_word;
               cnt_in = req_cnt;
            end
         end
         smacc_pkg::ST_EXEC: begin
            skip_in = 1'b0;
            iter_in = '0;
            case (op_ff) inside
               smacc_pkg::OP_LDA: a_in = opw_ff;
               smacc_pkg::OP_LDB: b_in = opw_ff;
               smacc_pkg::OP_ADD, smacc_pkg::OP_SUB: begin
                  alu_req.x = {1'b0, a_mag};
                  alu_req.y = {1'b0, w_mag};
                  if (a_sgn == eff_sgn) begin
                     // magnitudes add; carry into the sign position is overflow
                     a_in   = {a_sgn && (alu_rsp.res != '0), alu_rsp.res[MB-1:0]};
                     ovf_in = ovf_ff | alu_rsp.res[MB];
                  end else begin
                     alu_req.sub = 1'b1;
                     if (alu_rsp.cout) begin
                        a_in = {a_sgn && (alu_rsp.res[MB-1:0] != '0), alu_rsp.res[MB-1:0]};
                     end
                  end
               end
               smacc_pkg::OP_MPY: a_in = '0;
               smacc_pkg::OP_DIV: begin
                  alu_req.x   = {1'b0, a_mag};
                  alu_req.y   = {1'b0, w_mag};
                  alu_req.sub = 1'b1;
                  if (alu_rsp.cout) ovf_in = 1'b1;
               end
               smacc_pkg::OP_AND:  a_in = a_ff & opw_ff;
               smacc_pkg::OP_OR:   a_in = a_ff | opw_ff;
               smacc_pkg::OP_XOR:  a_in = a_ff ^ opw_ff;
               smacc_pkg::OP_SHR:  a_in = {a_sgn, a_mag >> cnt_ff};
               smacc_pkg::OP_SHL:  a_in = {a_sgn, a_mag << cnt_ff};
               smacc_pkg::OP_ATOB: b_in = a_ff;
               smacc_pkg::OP_SWAP: begin
                  a_in = b_ff;
                  b_in = a_ff;
               end
               smacc_pkg::OP_SKGT: begin
                  // A > w: same sign, |A| < |w| if negative, else |w| < |A|; else w < 0
                  alu_req.x   = a_neg ? {1'b0, a_mag} : {1'b0, w_mag};
                  alu_req.y   = a_neg ? {1'b0, w_mag} : {1'b0, a_mag};
                  alu_req.sub = 1'b1;
                  skip_in     = (a_neg == w_neg) ? !alu_rsp.cout : w_neg;
               end
               smacc_pkg::OP_SKNE: skip_in = (a_ff != opw_ff);
               default: ;
            endcase
         end
         smacc_pkg::ST_ADDNEG: begin
            alu_req.x   = {1'b0, w_mag};
            alu_req.y   = {1'b0, a_mag};
            alu_req.sub = 1'b1;
            a_in        = {eff_sgn, alu_rsp.res[MB-1:0]};
         end
         smacc_pkg::ST_MUL: begin
            // add multiplicand when the low multiplier bit is set, then shift A:B right
            alu_req.x = {1'b0, a_mag};
            alu_req.y = b_mag[0] ? {1'b0, w_mag} : '0;
            a_in      = {a_sgn, alu_rsp.res[MB:1]};
            b_in      = {b_sgn, alu_rsp.res[0], b_mag[MB-1:1]};
            iter_in   = iter_ff + smacc_pkg::ITER_W'(1);
         end
         smacc_pkg::ST_DIV: begin
            // restoring step: shift A:B left, trial subtract the divisor
            alu_req.x   = shifted;
            alu_req.y   = {1'b0, w_mag};
            alu_req.sub = 1'b1;
            a_in        = {a_sgn, alu_rsp.cout ? alu_rsp.res[MB-1:0] : shifted[MB-1:0]};
            b_in        = {b_sgn, b_mag[MB-2:0], alu_rsp.cout};
            iter_in     = iter_ff + smacc_pkg::ITER_W'(1);
         end
         smacc_pkg::ST_SIGN: begin
            if (op_ff == smacc_pkg::OP_MPY) begin
               a_in = {prod_sgn, a_mag};
               b_in = {prod_sgn, b_mag};
            end else begin
               a_in = {a_sgn && (a_mag != '0), a_mag};
               b_in = {(a_sgn ^ w_sgn) && (b_mag != '0), b_mag};
            end
         end
         smacc_pkg::ST_WB: push = slot_free;
         default: ;
      endcase
   end

   assign result.push  = push;
   assign result.acc_a = a_ff;
   assign result.acc_b = b_ff;
   assign result.ovf   = ovf_ff;
   assign result.skip  = skip_ff;

endmodule

FILE: rtl/sign_magnitude_accumulator_alu_core.sv
// Channel | Dir | Ports           | Payload
// req     | in  | req_t*          | tuser: req_type; tdata: operand_word, shift_count
// rsp     | out | rsp_t*          | tdata: acc_a, acc_b, overflow_flag, skip_taken,
//         |     |                 |        a_plus, a_minus, a_zero
// Load, logic, shift, transfer, compare and most add/subtract pass from ST_EXEC to ST_WB;
// add/subtract with opposite effective signs and |operand| above |A| adds ST_ADDNEG.
// Multiply and divide make 23 passes of the shared adder, one per magnitude bit, in
// ST_MUL or ST_DIV, then ST_SIGN; an improper divide goes from ST_EXEC to ST_WB.
// Reset clears A, B, overflow and the output valid flag. A stalled result holds in the
// output register while the next transaction is taken and computed.
// Top level; depends on smacc_pkg, smacc_engine and the assertion header.
`include "sign_magnitude_accumulator_alu_core_assert.svh"

module sign_magnitude_accumulator_alu_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [23:0] operand_word, [28:24] shift_count, rest zero
   input  logic [smacc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [3:0] req_type
   input  logic [smacc_pkg::OP_BITS-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [23:0] acc_a, [47:24] acc_b, [48] overflow_flag, [49] skip_taken,
   // [50] a_plus, [51] a_minus, [52] a_zero, rest zero
   output logic [smacc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam int MB  = smacc_pkg::MAG_BITS;
   localparam int PAD = smacc_pkg::RSP_DATA_BITS - smacc_pkg::RSP_FIELD_BITS;

   smacc_pkg::result_type result;
   logic rsp_valid_ff, rsp_valid_in;
   logic [smacc_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic slot_free, a_plus, a_minus, a_zero;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   smacc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (smacc_pkg::op_type'(req_tuser)),
      .req_word  (req_tdata[smacc_pkg::WORD_BITS-1:0]),
      .req_cnt   (req_tdata[smacc_pkg::WORD_BITS +: smacc_pkg::CNT_BITS]),
      .slot_free (slot_free),
      .result    (result)
   );

   assign a_minus = result.acc_a[MB];
   assign a_zero  = (result.acc_a[MB-1:0] == '0);
   assign a_plus  = !a_minus && !a_zero;

   always_comb begin
      rsp_valid_in = result.push || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (result.push) begin
         rsp_data_in = {{PAD{1'b0}}, a_zero, a_minus, a_plus, result.skip, result.ovf,
                        result.acc_b, result.acc_a};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SMACC_ASSERT_SAME(a_push_slot, clock, reset, result.push, (!rsp_tvalid || rsp_tready), "result pushed over a waiting transaction")
   `SMACC_ASSERT_SAME(a_push_busy, clock, reset, result.push, !req_tready, "ready raised while a result is pending")
   `SMACC_ASSERT_NEXT(a_accept_busy, clock, reset, (req_tvalid && req_tready), !req_tready, "ready held after accepting a transaction")

endmodule
